@@ sv/nectx_pkg.sv @@
// Shared types and constants of the NEC infrared frame transmitter.
package nectx_pkg;

   localparam int KEY_WORDS = 4;
   localparam int WORD_BITS = 16;
   localparam int NUM_REGS  = 6;

   localparam int KW_IDX_W  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam int WPOS_W    = $clog2(KEY_WORDS + 2);
   localparam int BPOS_W    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int TICK_W    = 16;
   localparam int ADDR_W    = 5;
   localparam int REG_IDX_W = 3;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_START = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_LEAD_MARK  = 4'd1,
      PH_LEAD_SPACE = 4'd2,
      PH_BIT_MARK   = 4'd3,
      PH_BIT_SPACE  = 4'd4,
      PH_STOP_MARK  = 4'd5,
      PH_GAP        = 4'd6
   } phase_type;

   localparam logic [REG_IDX_W-1:0] REG_LEADER_MARK  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_LEADER_SPACE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ONE_SPACE    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_REPEAT_GAP   = 3'd5;

   localparam logic [TICK_W-1:0] RST_LEADER_MARK  = 16'd4340;
   localparam logic [TICK_W-1:0] RST_LEADER_SPACE = 16'd4250;
   localparam logic [TICK_W-1:0] RST_BIT_MARK     = 16'd560;
   localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = 16'd560;
   localparam logic [TICK_W-1:0] RST_ONE_SPACE    = 16'd1690;
   localparam logic [TICK_W-1:0] RST_REPEAT_GAP   = 16'd5050;

   localparam logic [15:0] CSR_DATA_MASK = 16'hFFFF;

endpackage

@@ sv/nectx_if.sv @@
// Request and response channel interfaces of the NEC infrared frame transmitter.
interface nectx_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      cmd;
   logic [1:0]                      word_index;
   logic [15:0]                     word_value;
   logic [7:0]                      protocol;

   modport source (output valid, cmd, word_index, word_value, protocol, input ready);
   modport sink   (input valid, cmd, word_index, word_value, protocol, output ready);
endinterface

interface nectx_rsp_if;
   logic valid;
   logic ready;
   logic carrier_on;
   logic busy_res;
   logic done_res;

   modport source (output valid, carrier_on, busy_res, done_res, input ready);
   modport sink   (input valid, carrier_on, busy_res, done_res, output ready);
endinterface

@@ sv/nec_ir_frame_transmitter.sv @@
// Top level of the NEC infrared frame transmitter: sequencer, key word memory and CSRs.
//
// The block takes one command beat per clock and returns exactly one response
// beat for each, in the cycle after, through a response register; a new command is
// taken in the same cycle as a waiting response leaves, so the sustained rate is
// one beat per clock whenever the response side keeps up. A tick beat moves the
// carrier waveform by one microsecond: leader mark and space, sixteen bits of each
// stored key word up to the first zero word, a stop mark, a repeat gap and then
// the whole frame once more. The four key words live in a small synchronous
// memory whose read port is exercised every cycle at the address the next beat
// may need (the current word, or the following one during the last bit space);
// a key word write in the same cycle is forwarded into the read data, and a valid
// bit per entry makes unwritten words read as zero after reset. The six timing
// registers sit on an APB-style port at byte addresses 0 to 20; a length of zero
// is treated as one tick. Registers should be written only while no frame is
// being sent.
module nec_ir_frame_transmitter (
   input  logic                       clock,
   input  logic                       reset,
   nectx_req_if.sink                  req_ch,
   nectx_rsp_if.source                rsp_ch,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [nectx_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import nectx_pkg::*;

   // Timing registers.
   logic [TICK_W-1:0]    cfg_ff [NUM_REGS];
   logic [REG_IDX_W-1:0] csr_idx;

   // Key word memory with per-entry valid bits.
   logic [WORD_BITS-1:0] mem [KEY_WORDS];
   logic [KEY_WORDS-1:0] kvalid_ff;
   logic [WORD_BITS-1:0] word_ff;
   logic                 word_ok_ff;
   logic [WPOS_W-1:0]    rd_addr;
   logic                 rd_in_range;
   logic                 wr_en;
   logic [KW_IDX_W-1:0]  wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // Sequencer state.
   phase_type            phase_ff, phase_in;
   logic [TICK_W-1:0]    ticks_ff, ticks_in;
   logic [WPOS_W-1:0]    wpos_ff, wpos_in;
   logic [BPOS_W-1:0]    bpos_ff, bpos_in;
   logic                 second_ff, second_in;

   // Response register.
   logic                 rsp_valid_ff;
   logic                 carrier_ff, busy_ff, done_ff;
   logic                 carrier_in, busy_in, done_in;

   logic                 accept;
   cmd_type              cmd;
   logic [BPOS_W-1:0]    bit_sel;
   logic                 cur_bit;
   logic                 word_live;

   function automatic logic [TICK_W-1:0] span(input logic [TICK_W-1:0] len);
      span = (len == '0) ? TICK_W'(1) : len;
   endfunction

   function automatic logic is_mark(input phase_type ph);
      is_mark = (ph == PH_LEAD_MARK) || (ph == PH_BIT_MARK) || (ph == PH_STOP_MARK);
   endfunction

   // ------------------------------------------------------------------
   // CSR port
   // ------------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_idx = paddr[ADDR_W-1:2];

   always_comb begin
      prdata = '0;
      if (32'(csr_idx) < 32'(NUM_REGS)) begin
         prdata = 32'(cfg_ff[csr_idx]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_LEADER_MARK]  <= RST_LEADER_MARK;
         cfg_ff[REG_LEADER_SPACE] <= RST_LEADER_SPACE;
         cfg_ff[REG_BIT_MARK]     <= RST_BIT_MARK;
         cfg_ff[REG_ZERO_SPACE]   <= RST_ZERO_SPACE;
         cfg_ff[REG_ONE_SPACE]    <= RST_ONE_SPACE;
         cfg_ff[REG_REPEAT_GAP]   <= RST_REPEAT_GAP;
      end else if (psel && penable && pwrite && pready &&
                   (32'(csr_idx) < 32'(NUM_REGS))) begin
         cfg_ff[csr_idx] <= pwdata[15:0] & CSR_DATA_MASK;
      end
   end

   // ------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------
   // The response register frees itself in the same cycle it is drained.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign cmd          = cmd_type'(req_ch.cmd);

   // ------------------------------------------------------------------
   // Key word memory
   // ------------------------------------------------------------------
   assign wr_en   = accept && (cmd == CMD_WRITE) &&
                    (32'(req_ch.word_index) < 32'(KEY_WORDS));
   assign wr_addr = KW_IDX_W'(req_ch.word_index);
   assign wr_data = WORD_BITS'(req_ch.word_value);

   // During the last bit space the next beat may need the following word to
   // decide between another word and the stop mark; otherwise the current one.
   always_comb begin
      if (phase_in == PH_BIT_SPACE && bpos_in == BPOS_W'(WORD_BITS - 1)) begin
         rd_addr = wpos_in + WPOS_W'(1);
      end else begin
         rd_addr = wpos_in;
      end
   end
   assign rd_in_range = 32'(rd_addr) < 32'(KEY_WORDS);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && rd_in_range && (wr_addr == rd_addr[KW_IDX_W-1:0])) begin
         word_ff <= wr_data;
      end else begin
         word_ff <= mem[rd_addr[KW_IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kvalid_ff  <= '0;
         word_ok_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            kvalid_ff[wr_addr] <= 1'b1;
         end
         word_ok_ff <= rd_in_range &&
                       (kvalid_ff[rd_addr[KW_IDX_W-1:0]] ||
                        (wr_en && (wr_addr == rd_addr[KW_IDX_W-1:0])));
      end
   end

   // A word that was never written, or lies past the last entry, reads as zero.
   assign word_live = word_ok_ff && (word_ff != '0);
   assign bit_sel   = BPOS_W'(WORD_BITS - 1) - bpos_ff;
   assign cur_bit   = word_ok_ff && word_ff[bit_sel];

   // ------------------------------------------------------------------
   // Sequencer next state
   // ------------------------------------------------------------------
   always_comb begin
      phase_in  = phase_ff;
      ticks_in  = ticks_ff;
      wpos_in   = wpos_ff;
      bpos_in   = bpos_ff;
      second_in = second_ff;
      if (accept) begin
         unique case (cmd)
            CMD_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (ticks_ff > TICK_W'(1)) begin
                     ticks_in = ticks_ff - TICK_W'(1);
                  end else begin
                     unique case (phase_ff)
                        PH_LEAD_MARK: begin
                           phase_in = PH_LEAD_SPACE;
                           ticks_in = span(cfg_ff[REG_LEADER_SPACE]);
                        end
                        PH_LEAD_SPACE: begin
                           // The word position is already zero here.
                           wpos_in = '0;
                           bpos_in = '0;
                           if (word_live) begin
                              phase_in = PH_BIT_MARK;
                           end else begin
                              phase_in = PH_STOP_MARK;
                           end
                           ticks_in = span(cfg_ff[REG_BIT_MARK]);
                        end
                        PH_BIT_MARK: begin
                           phase_in = PH_BIT_SPACE;
                           ticks_in = cur_bit ? span(cfg_ff[REG_ONE_SPACE])
                                              : span(cfg_ff[REG_ZERO_SPACE]);
                        end
                        PH_BIT_SPACE: begin
                           if (bpos_ff == BPOS_W'(WORD_BITS - 1)) begin
                              bpos_in = '0;
                              wpos_in = wpos_ff + WPOS_W'(1);
                              phase_in = word_live ? PH_BIT_MARK : PH_STOP_MARK;
                           end else begin
                              bpos_in  = bpos_ff + BPOS_W'(1);
                              phase_in = PH_BIT_MARK;
                           end
                           ticks_in = span(cfg_ff[REG_BIT_MARK]);
                        end
                        PH_STOP_MARK: begin
                           if (!second_ff) begin
                              phase_in = PH_GAP;
                              ticks_in = span(cfg_ff[REG_REPEAT_GAP]);
                           end else begin
                              phase_in  = PH_IDLE;
                              ticks_in  = '0;
                              wpos_in   = '0;
                              bpos_in   = '0;
                              second_in = 1'b0;
                           end
                        end
                        PH_GAP: begin
                           second_in = 1'b1;
                           wpos_in   = '0;
                           bpos_in   = '0;
                           phase_in  = PH_LEAD_MARK;
                           ticks_in  = span(cfg_ff[REG_LEADER_MARK]);
                        end
                        default: begin
                           phase_in = PH_IDLE;
                           ticks_in = '0;
                        end
                     endcase
                  end
               end
            end
            CMD_START: begin
               if (phase_ff == PH_IDLE && req_ch.protocol == 8'd0) begin
                  wpos_in   = '0;
                  bpos_in   = '0;
                  second_in = 1'b0;
                  phase_in  = PH_LEAD_MARK;
                  ticks_in  = span(cfg_ff[REG_LEADER_MARK]);
               end
            end
            CMD_WRITE, CMD_NONE: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Response fields
   // ------------------------------------------------------------------
   always_comb begin
      if (cmd == CMD_TICK) begin
         carrier_in = (phase_ff != PH_IDLE) && is_mark(phase_ff);
         busy_in    = phase_ff != PH_IDLE;
         done_in    = (phase_ff == PH_STOP_MARK) && second_ff &&
                      (ticks_ff <= TICK_W'(1));
      end else begin
         carrier_in = is_mark(phase_in);
         busy_in    = phase_in != PH_IDLE;
         done_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         ticks_ff     <= '0;
         wpos_ff      <= '0;
         bpos_ff      <= '0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         ticks_ff  <= ticks_in;
         wpos_ff   <= wpos_in;
         bpos_ff   <= bpos_in;
         second_ff <= second_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         carrier_ff <= carrier_in;
         busy_ff    <= busy_in;
         done_ff    <= done_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.carrier_on = carrier_ff;
   assign rsp_ch.busy_res   = busy_ff;
   assign rsp_ch.done_res   = done_ff;

endmodule

@@ test/nec_ir_frame_transmitter_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the NEC infrared frame transmitter with its own waveform predictor.
module nec_ir_frame_transmitter_tb;
   import nectx_pkg::*;

   // One command beat as offered on the request channel.
   typedef struct {
      cmd_type     cmd;
      logic [1:0]  index;
      logic [15:0] value;
      logic [7:0]  proto;
   } ir_command_type;

   // One status beat as returned on the response channel.
   typedef struct packed {
      logic carrier;
      logic busy;
      logic done;
   } ir_status_type;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   nectx_req_if req_ch();
   nectx_rsp_if rsp_ch();

   nec_ir_frame_transmitter dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predicted state of the transmitter. It advances only when a command beat is
   // accepted, so it always describes the block as of the last accepted beat.
   logic [TICK_W-1:0]    timing [NUM_REGS];
   logic [WORD_BITS-1:0] keys [KEY_WORDS];
   phase_type            ph;
   logic [TICK_W-1:0]    remain;
   int                   word_at;
   int                   bit_at;
   logic                 second_pass;

   // Status beats still owed by the block, oldest first.
   ir_status_type expected_status [$];

   int   mismatch_count;
   int   status_beats;
   int   send_idle_pct;
   int   rsp_stall_pct;
   int   hold_len;
   logic rsp_hold;
   event hold_kick;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs; the slowest legal run is far shorter.
   initial begin
      #1_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------
   // Waveform predictor
   // ------------------------------------------------------------------

   function automatic void reset_model();
      timing[REG_LEADER_MARK]  = RST_LEADER_MARK;
      timing[REG_LEADER_SPACE] = RST_LEADER_SPACE;
      timing[REG_BIT_MARK]     = RST_BIT_MARK;
      timing[REG_ZERO_SPACE]   = RST_ZERO_SPACE;
      timing[REG_ONE_SPACE]    = RST_ONE_SPACE;
      timing[REG_REPEAT_GAP]   = RST_REPEAT_GAP;
      for (int i = 0; i < KEY_WORDS; i++) begin
         keys[i] = '0;
      end
      ph          = PH_IDLE;
      remain      = '0;
      word_at     = 0;
      bit_at      = 0;
      second_pass = 1'b0;
   endfunction

   // Enter a phase whose length comes from a timing register; a programmed
   // length of zero still lasts one tick.
   function automatic void load_phase(phase_type p, logic [REG_IDX_W-1:0] r);
      ph     = p;
      remain = (timing[r] == '0) ? TICK_W'(1) : timing[r];
   endfunction

   // A word is sent only if it exists and is nonzero; otherwise the frame
   // closes with the stop mark.
   function automatic void begin_word();
      logic nonzero;
      nonzero = 1'b0;
      if (word_at < KEY_WORDS) begin
         nonzero = (keys[word_at] != '0);
      end
      if (nonzero) begin
         bit_at = 0;
         load_phase(PH_BIT_MARK, REG_BIT_MARK);
      end else begin
         load_phase(PH_STOP_MARK, REG_BIT_MARK);
      end
   endfunction

   function automatic logic in_mark();
      return (ph == PH_LEAD_MARK) || (ph == PH_BIT_MARK) || (ph == PH_STOP_MARK);
   endfunction

   // Applies one accepted command to the predicted state and returns the
   // status beat that the block must answer with.
   function automatic ir_status_type advance_waveform(ir_command_type c);
      ir_status_type        s;
      logic [WORD_BITS-1:0] w;
      s = '0;
      if (c.cmd == CMD_TICK) begin
         if (ph != PH_IDLE) begin
            // Carrier reflects the phase during this tick, before any change.
            s.carrier = in_mark();
            s.busy    = 1'b1;
            if (remain > 1) begin
               remain--;
            end else begin
               remain = '0;
               case (ph)
                  PH_LEAD_MARK: begin
                     load_phase(PH_LEAD_SPACE, REG_LEADER_SPACE);
                  end
                  PH_LEAD_SPACE: begin
                     word_at = 0;
                     begin_word();
                  end
                  PH_BIT_MARK: begin
                     // The bit is taken from the stored word only now, so a
                     // write during the frame affects every later bit.
                     w = (word_at < KEY_WORDS) ? keys[word_at] : '0;
                     load_phase(PH_BIT_SPACE,
                                w[WORD_BITS-1-bit_at] ? REG_ONE_SPACE : REG_ZERO_SPACE);
                  end
                  PH_BIT_SPACE: begin
                     bit_at++;
                     if (bit_at >= WORD_BITS) begin
                        bit_at = 0;
                        word_at++;
                        begin_word();
                     end else begin
                        load_phase(PH_BIT_MARK, REG_BIT_MARK);
                     end
                  end
                  PH_STOP_MARK: begin
                     if (!second_pass) begin
                        load_phase(PH_GAP, REG_REPEAT_GAP);
                     end else begin
                        // End of the repeated copy: busy still reads high here.
                        s.done      = 1'b1;
                        ph          = PH_IDLE;
                        word_at     = 0;
                        bit_at      = 0;
                        second_pass = 1'b0;
                     end
                  end
                  PH_GAP: begin
                     second_pass = 1'b1;
                     word_at     = 0;
                     bit_at      = 0;
                     load_phase(PH_LEAD_MARK, REG_LEADER_MARK);
                  end
                  default: begin
                     ph = PH_IDLE;
                  end
               endcase
            end
         end
      end else begin
         if (c.cmd == CMD_WRITE) begin
            keys[c.index] = c.value;
         end else if (c.cmd == CMD_START && ph == PH_IDLE && c.proto == 8'd0) begin
            // Only an idle block starts, and only for the NEC protocol.
            word_at     = 0;
            bit_at      = 0;
            second_pass = 1'b0;
            load_phase(PH_LEAD_MARK, REG_LEADER_MARK);
         end
         // Non-tick commands report the phase after the command.
         s.carrier = in_mark();
         s.busy    = (ph != PH_IDLE);
      end
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Channel drivers and the status checker
   // ------------------------------------------------------------------

   function automatic ir_command_type make_command(cmd_type c, logic [1:0] i,
                                                   logic [15:0] v, logic [7:0] p);
      ir_command_type x;
      x.cmd   = c;
      x.index = i;
      x.value = v;
      x.proto = p;
      return x;
   endfunction

   // Offers one command beat, with a random idle gap in front of it, and
   // records the predicted status once the block takes it. Valid is left high
   // after acceptance so back-to-back beats need no second assignment in the
   // same step; whoever stops sending lowers it.
   task automatic send_beat(ir_command_type c);
      int gap;
      gap = 0;
      if (send_idle_pct > 0) begin
         while ($urandom_range(99) < send_idle_pct) gap++;
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= c.cmd;
      req_ch.word_index <= c.index;
      req_ch.word_value <= c.value;
      req_ch.protocol   <= c.proto;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_status.push_back(advance_waveform(c));
   endtask

   task automatic send_tick();
      send_beat(make_command(CMD_TICK, 2'd0, 16'd0, 8'd0));
   endtask

   // Ticks until the predicted frame has run out.
   task automatic finish_frame();
      while (ph != PH_IDLE) send_tick();
   endtask

   // Stops sending and waits for every owed status beat.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("[%0t] %s: expected %0h got %0h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // Setup cycle, then access cycle; the register takes the data at the edge
   // where the access cycle meets pready. The bus then returns to idle.
   task automatic csr_write(logic [REG_IDX_W-1:0] r, logic [TICK_W-1:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= {16'd0, v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      timing[r] = v;
      @(posedge clock);
   endtask

   // Reads one timing register and compares it with the predicted value.
   task automatic csr_check(logic [REG_IDX_W-1:0] r);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {r, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== 32'(timing[r])) begin
         report_mismatch($sformatf("register %0d read", r), 32'(timing[r]), prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // New timing is only programmed with no frame running and nothing in flight.
   task automatic retime(logic [TICK_W-1:0] lead_mark, logic [TICK_W-1:0] lead_space,
                         logic [TICK_W-1:0] mark, logic [TICK_W-1:0] zero_space,
                         logic [TICK_W-1:0] one_space, logic [TICK_W-1:0] gap);
      finish_frame();
      drain();
      csr_write(REG_LEADER_MARK, lead_mark);
      csr_write(REG_LEADER_SPACE, lead_space);
      csr_write(REG_BIT_MARK, mark);
      csr_write(REG_ZERO_SPACE, zero_space);
      csr_write(REG_ONE_SPACE, one_space);
      csr_write(REG_REPEAT_GAP, gap);
   endtask

   // Every accepted status beat is matched against the oldest prediction.
   always @(posedge clock) begin : check_status
      ir_status_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         status_beats++;
         if (expected_status.size() == 0) begin
            report_mismatch($sformatf("status beat %0d with nothing outstanding",
                                      status_beats), 32'd0, 32'd1);
         end else begin
            want = expected_status.pop_front();
            if (rsp_ch.carrier_on !== want.carrier) begin
               report_mismatch($sformatf("status beat %0d carrier_on", status_beats),
                               32'(want.carrier), 32'(rsp_ch.carrier_on));
            end
            if (rsp_ch.busy_res !== want.busy) begin
               report_mismatch($sformatf("status beat %0d busy_res", status_beats),
                               32'(want.busy), 32'(rsp_ch.busy_res));
            end
            if (rsp_ch.done_res !== want.done) begin
               report_mismatch($sformatf("status beat %0d done_res", status_beats),
                               32'(want.done), 32'(rsp_ch.done_res));
            end
         end
      end
   end

   // Response-side flow control: random stalls, overridden by a long hold-off.
   always @(posedge clock) begin
      rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // The long hold-off counts its own cycles so the sender keeps pushing beats
   // into the block the whole time.
   initial begin
      rsp_hold = 1'b0;
      forever begin
         @(hold_kick);
         rsp_hold <= 1'b1;
         repeat (hold_len) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // The timing registers come out of reset at the package RST_ lengths, and
   // a start for a foreign protocol leaves the block idle.
   task automatic test_reset_timing();
      csr_check(REG_LEADER_MARK);
      csr_check(REG_LEADER_SPACE);
      csr_check(REG_BIT_MARK);
      csr_check(REG_ZERO_SPACE);
      csr_check(REG_ONE_SPACE);
      csr_check(REG_REPEAT_GAP);
      send_beat(make_command(CMD_WRITE, 2'd0, 16'h8001, 8'd0));
      send_beat(make_command(CMD_START, 2'd0, 16'd0, 8'h02));
      send_tick();
   endtask

   // Short timing so the special cases are cheap to walk through.
   task automatic test_directed();
      retime(16'd2, 16'd1, 16'd1, 16'd0, 16'd2, 16'd3);
      // Idle tick, the unused command, and starts for foreign protocols.
      send_tick();
      send_beat(make_command(CMD_NONE, 2'd3, 16'hFFFF, 8'hFF));
      send_beat(make_command(CMD_START, 2'd0, 16'd0, 8'hFF));
      send_beat(make_command(CMD_START, 2'd0, 16'd0, 8'h01));
      // The word after the first zero word must never be sent.
      send_beat(make_command(CMD_WRITE, 2'd3, 16'h8000, 8'd0));
      send_beat(make_command(CMD_WRITE, 2'd0, 16'hFFFF, 8'd0));
      send_beat(make_command(CMD_WRITE, 2'd1, 16'h0001, 8'd0));
      send_beat(make_command(CMD_WRITE, 2'd2, 16'h0000, 8'd0));
      send_beat(make_command(CMD_START, 2'd0, 16'd0, 8'd0));
      // A second start while busy is ignored, and so is the unused command.
      send_beat(make_command(CMD_START, 2'd0, 16'd0, 8'd0));
      send_beat(make_command(CMD_NONE, 2'd0, 16'd0, 8'd0));
      repeat (5) send_tick();
      // Rewriting a word mid-frame changes the bits that are still to come.
      send_beat(make_command(CMD_WRITE, 2'd1, 16'h8000, 8'd0));
      finish_frame();
      // With an empty word list the frame is just leader and stop mark, twice.
      send_beat(make_command(CMD_WRITE, 2'd0, 16'h0000, 8'd0));
      send_beat(make_command(CMD_START, 2'd0, 16'd0, 8'd0));
      finish_frame();
   endtask

   // A long leader mark with every other length at zero, which still lasts
   // one tick.
   task automatic test_timing_extremes();
      retime(16'd12, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_beat(make_command(CMD_WRITE, 2'd0, 16'h8001, 8'd0));
      send_beat(make_command(CMD_WRITE, 2'd1, 16'h0000, 8'd0));
      send_beat(make_command(CMD_START, 2'd0, 16'd0, 8'd0));
      finish_frame();
   endtask

   // Commands are biased by the predicted phase: an idle block mostly gets
   // words and starts, a busy one mostly ticks with the odd write or start.
   // Zero words come up often so that frames stay short.
   function automatic ir_command_type random_cmd();
      ir_command_type c;
      int             pick;
      c.index = 2'($urandom_range(0, 3));
      c.proto = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0: c.value = 16'h0000;
         1: c.value = 16'hFFFF;
         default: c.value = 16'($urandom_range(1, 65535));
      endcase
      pick = $urandom_range(99);
      if (ph == PH_IDLE) begin
         if (pick < 45) c.cmd = CMD_WRITE;
         else if (pick < 85) c.cmd = CMD_START;
         else if (pick < 93) c.cmd = CMD_TICK;
         else c.cmd = CMD_NONE;
      end else begin
         if (pick < 88) c.cmd = CMD_TICK;
         else if (pick < 94) c.cmd = CMD_WRITE;
         else if (pick < 98) c.cmd = CMD_START;
         else c.cmd = CMD_NONE;
      end
      if (c.cmd == CMD_START && $urandom_range(99) < 85) begin
         c.proto = 8'd0;
      end
      return c;
   endfunction

   task automatic test_random_traffic(int send_pct, int stall_pct, int beats);
      retime(16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
             16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)),
             16'($urandom_range(0, 1)), 16'($urandom_range(0, 2)));
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (beats) send_beat(random_cmd());
   endtask

   // The response side holds off for a long stretch while ticks keep coming,
   // so the block fills up and must stall its request side.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      retime(16'd2, 16'd1, 16'd1, 16'd1, 16'd2, 16'd2);
      send_beat(make_command(CMD_WRITE, 2'd0, 16'hC3A5, 8'd0));
      send_beat(make_command(CMD_START, 2'd0, 16'd0, 8'd0));
      hold_len = 300;
      -> hold_kick;
      repeat (60) send_tick();
      finish_frame();
      drain();
   endtask

   initial begin
      reset             <= 1'b1;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.cmd        <= CMD_TICK;
      req_ch.word_index <= '0;
      req_ch.word_value <= '0;
      req_ch.protocol   <= '0;
      mismatch_count = 0;
      status_beats   = 0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      hold_len       = 0;
      reset_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_timing();
      test_directed();
      test_timing_extremes();
      test_random_traffic(0, 0, 30);
      test_random_traffic(77, 0, 30);
      test_random_traffic(0, 77, 30);
      test_random_traffic(14, 14, 30);
      test_backpressure();

      finish_frame();
      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
